FILE: hdl/can_bit_timing_solver_assert.svh
// Assertion macros shared by the bit timing solver modules.
// Each one expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef CAN_BIT_TIMING_SOLVER_ASSERT_SVH
`define CAN_BIT_TIMING_SOLVER_ASSERT_SVH

// A property that is checked at every clock edge outside reset.
`define CBTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that is checked at every clock edge outside reset.
`define CBTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbts_pkg.sv
`default_nettype none

package cbts_pkg;

  // Search limits.
  localparam int unsigned MAX_PRESCALER = 64;
  localparam int unsigned MIN_QUANTA    = 8;
  localparam int unsigned MAX_QUANTA    = 25;

  // Bit rates selected by the rate code.
  localparam int unsigned NUM_RATES = 8;
  localparam int unsigned RATE_BPS [NUM_RATES] = '{
    10000, 20000, 50000, 125000, 250000, 500000, 800000, 1000000
  };
  localparam int unsigned MAX_RATE_BPS = 1000000;

  // Field widths of the transactions.
  localparam int unsigned RATE_CODE_W = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PRESC_W     = 7;
  localparam int unsigned QUANTA_W    = 5;
  localparam int unsigned SEG_W       = 4;
  localparam int unsigned CLK_W       = 28;

  // Internal widths.
  localparam int unsigned RATE_IDX_W = $clog2(NUM_RATES);
  localparam int unsigned RATE_W     = $clog2(MAX_RATE_BPS + 1);
  localparam int unsigned PROD_W     = $clog2(MAX_RATE_BPS * MAX_QUANTA + 1);
  localparam int unsigned DVS_W      = $clog2(2 * MAX_PRESCALER + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(CLK_W + 1);

  localparam logic [CLK_W-1:0] CLK_HZ_RESET = CLK_W'(60000000);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_TOO_HIGH = 2'd2,
    ST_TOO_LOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_Q_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CLK_W-1:0]  quotient;
    logic [DVS_W-1:0]  remainder;
  } div_rsp_t;

  // Bit rate of a valid code.
  function automatic logic [RATE_W-1:0] rate_bps(input logic [RATE_IDX_W-1:0] idx);
    return RATE_W'(RATE_BPS[idx]);
  endfunction

  // Quantum frequency that the largest quanta count needs at this rate.
  function automatic logic [PROD_W-1:0] rate_top_prod(input logic [RATE_IDX_W-1:0] idx);
    return PROD_W'(RATE_BPS[idx] * MAX_QUANTA);
  endfunction

  // Smallest quantum frequency that still reaches this rate.
  function automatic logic [CLK_W-1:0] rate_low_prod(input logic [RATE_IDX_W-1:0] idx);
    return CLK_W'(RATE_BPS[idx] * MIN_QUANTA);
  endfunction

  // Phase segment length, (q - 1) / 3, by reciprocal multiply (exact below 64).
  function automatic logic [SEG_W-1:0] phase_len(input logic [QUANTA_W-1:0] q);
    logic [QUANTA_W-1:0] qm1;
    logic [QUANTA_W+8:0] prod;
    qm1  = q - QUANTA_W'(1);
    prod = (QUANTA_W + 9)'(qm1) * (QUANTA_W + 9)'(171);
    return SEG_W'(prod >> 9);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cbts_if.sv
`default_nettype none

interface cbts_in_if import cbts_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RATE_CODE_W-1:0] rate_code;

  modport source (output valid, output rate_code, input ready);
  modport sink   (input valid, input rate_code, output ready);
endinterface

interface cbts_out_if import cbts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PRESC_W-1:0]  prescaler;
  logic [QUANTA_W-1:0] quanta_per_bit;
  logic                jump_width;
  logic [SEG_W-1:0]    prop_segment;
  logic [SEG_W-1:0]    phase_segment_one;
  logic [SEG_W-1:0]    phase_segment_two;

  modport source (
    output valid, output status, output prescaler, output quanta_per_bit,
    output jump_width, output prop_segment, output phase_segment_one,
    output phase_segment_two, input ready
  );
  modport sink (
    input valid, input status, input prescaler, input quanta_per_bit,
    input jump_width, input prop_segment, input phase_segment_one,
    input phase_segment_two, output ready
  );
endinterface

`default_nettype wire

FILE: hdl/cbts_divider.sv
`default_nettype none
`include "can_bit_timing_solver_assert.svh"

// Restoring divider, one quotient bit per cycle. Quotient bits shift into
// the low end of the dividend register as its high bits are consumed.
module cbts_divider import cbts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CLK_W-1:0]     dvd_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     divisor_r;

  logic [DVS_W:0]       trial;
  logic                 fits;
  logic [DVS_W-1:0]     step_rem;

  always_comb begin
    trial    = {rem_r, dvd_r[CLK_W-1]};
    fits     = trial >= {1'b0, divisor_r};
    step_rem = fits ? DVS_W'(trial - {1'b0, divisor_r}) : DVS_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(CLK_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[CLK_W-2:0], fits};
      rem_r <= step_rem;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

  `CBTS_ASSERT_IMP(a_div_no_restart, req.start, !busy_r, "divider restarted while busy")
  `CBTS_ASSERT_IMP(a_div_rem_range, done_r, rem_r < divisor_r, "remainder not below divisor")
  `CBTS_ASSERT_IMP(a_div_done_idle, done_r, !busy_r, "divider done while still busy")

endmodule

`default_nettype wire

FILE: hdl/can_bit_timing_solver.sv
`default_nettype none
`include "can_bit_timing_solver_assert.svh"

// CAN bit timing solver. Each input transaction carries a rate code (0..7 for
// 10k, 20k, 50k, 125k, 250k, 500k, 800k and 1M bit/s) and yields exactly one
// result transaction holding a status, the baud prescaler, the quanta per bit,
// the jump width and the three segment lengths. The prescaler search runs from
// 1 up to 64; a prescaler p is usable when the system clock divides evenly by
// 2p, giving a quantum frequency of clock / (2p). For each usable prescaler
// the quanta count is scanned from 25 down to 8 for an exact hit, so the first
// hit has the lowest prescaler and then the highest quanta count. Status is
// ok, bad code (codes 8..15), rate too high (decided at prescaler 1 only) or
// rate too low (no exact hit); when it is not ok all other fields are zero.
// The system clock register is written through cfg_we/cfg_wdata and resets to
// 60 MHz; write it only while no transaction is in flight. Every prescaler
// runs the bit-serial divider (one bit of the 28-bit clock per cycle), and a
// usable one that is not too high also a scan of up to 18 quanta counts; a bad
// code goes straight to the finish state. The input is not ready during a
// search, but a new transaction is taken while a finished result still waits
// in the output register.
module can_bit_timing_solver import cbts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CLK_W-1:0] cfg_wdata,
  cbts_in_if.sink               in_ch,
  cbts_out_if.source            out_ch
);

  localparam int unsigned P_W = $clog2(MAX_PRESCALER + 1);
  localparam int unsigned Q_W = $clog2(MAX_QUANTA + 1);

  // Configuration register.
  logic [CLK_W-1:0] clk_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_HZ_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  // Sequencer and search registers.
  state_t                state_r, state_nxt;
  logic [RATE_IDX_W-1:0] code_r;
  logic [RATE_W-1:0]     bit_r;
  logic [P_W-1:0]        p_r;
  logic [Q_W-1:0]        q_r;
  logic [PROD_W-1:0]     prod_r;
  logic [CLK_W-1:0]      tq_r;
  status_t               res_status_r;
  logic [P_W-1:0]        res_p_r;
  logic [Q_W-1:0]        res_q_r;

  // Output register.
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [PRESC_W-1:0]    out_presc_r;
  logic [QUANTA_W-1:0]   out_quanta_r;
  logic                  out_sjw_r;
  logic [SEG_W-1:0]      out_prop_r;
  logic [SEG_W-1:0]      out_phase_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cbts_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Status of the search step in this cycle.
  logic in_fire;
  logic code_bad;
  logic out_free;
  logic div_uneven;
  logic too_high;
  logic q_hit;
  logic last_q;
  logic last_p;

  always_comb begin
    in_fire    = in_ch.valid && in_ch.ready;
    code_bad   = in_ch.rate_code >= RATE_CODE_W'(NUM_RATES);
    out_free   = !out_valid_r || out_ch.ready;
    div_uneven = div_rsp.remainder != '0;
    too_high   = (p_r == P_W'(1)) && (div_rsp.quotient < rate_low_prod(code_r));
    q_hit      = CLK_W'(prod_r) == tq_r;
    last_q     = q_r == Q_W'(MIN_QUANTA);
    last_p     = p_r == P_W'(MAX_PRESCALER);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = code_bad ? S_FINISH : S_DIV_START;
        end
      end
      S_DIV_START: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        priority if (!div_rsp.done) begin
          state_nxt = S_DIV_WAIT;
        end else if (div_uneven) begin
          state_nxt = last_p ? S_FINISH : S_DIV_START;
        end else if (too_high) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        priority if (q_hit) begin
          state_nxt = S_FINISH;
        end else if (last_q) begin
          state_nxt = last_p ? S_FINISH : S_DIV_START;
        end else begin
          state_nxt = S_Q_SCAN;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control strobes.
  logic    take_item;
  logic    p_inc;
  logic    scan_init;
  logic    scan_step;
  logic    res_set;
  status_t res_status;
  logic    out_load;

  always_comb begin
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = clk_hz_r;
    div_req.divisor  = DVS_W'({p_r, 1'b0});
    take_item        = 1'b0;
    p_inc            = 1'b0;
    scan_init        = 1'b0;
    scan_step        = 1'b0;
    res_set          = 1'b0;
    res_status       = ST_OK;
    out_load         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        take_item   = in_fire;
        if (in_fire && code_bad) begin
          res_set    = 1'b1;
          res_status = ST_BAD_CODE;
        end
      end
      S_DIV_START: begin
        div_req.start = 1'b1;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          priority if (div_uneven) begin
            if (last_p) begin
              res_set    = 1'b1;
              res_status = ST_TOO_LOW;
            end else begin
              p_inc = 1'b1;
            end
          end else if (too_high) begin
            res_set    = 1'b1;
            res_status = ST_TOO_HIGH;
          end else begin
            scan_init = 1'b1;
          end
        end
      end
      S_Q_SCAN: begin
        priority if (q_hit) begin
          res_set    = 1'b1;
          res_status = ST_OK;
        end else if (last_q) begin
          if (last_p) begin
            res_set    = 1'b1;
            res_status = ST_TOO_LOW;
          end else begin
            p_inc = 1'b1;
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search datapath. The quanta scan keeps prod_r equal to bit rate times
  // quanta count, so an exact hit is a plain compare with the quantum frequency.
  always_ff @(posedge clk) begin
    if (take_item) begin
      code_r <= in_ch.rate_code[RATE_IDX_W-1:0];
      bit_r  <= rate_bps(in_ch.rate_code[RATE_IDX_W-1:0]);
      p_r    <= P_W'(1);
    end else if (p_inc) begin
      p_r <= p_r + P_W'(1);
    end
    if (scan_init) begin
      q_r    <= Q_W'(MAX_QUANTA);
      prod_r <= rate_top_prod(code_r);
      tq_r   <= div_rsp.quotient;
    end else if (scan_step) begin
      q_r    <= q_r - Q_W'(1);
      prod_r <= prod_r - PROD_W'(bit_r);
    end
    if (res_set) begin
      res_status_r <= res_status;
      res_p_r      <= (res_status == ST_OK) ? p_r : '0;
      res_q_r      <= (res_status == ST_OK) ? q_r : '0;
    end
  end

  // Result register. A failed search clears every field except the status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_presc_r  <= PRESC_W'(res_p_r);
      out_quanta_r <= QUANTA_W'(res_q_r);
      if (res_status_r == ST_OK) begin
        out_sjw_r   <= 1'b1;
        out_phase_r <= phase_len(QUANTA_W'(res_q_r));
        out_prop_r  <= SEG_W'(QUANTA_W'(res_q_r) - QUANTA_W'(1)
                       - {phase_len(QUANTA_W'(res_q_r)), 1'b0});
      end else begin
        out_sjw_r   <= 1'b0;
        out_phase_r <= '0;
        out_prop_r  <= '0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.prescaler         = out_presc_r;
  assign out_ch.quanta_per_bit    = out_quanta_r;
  assign out_ch.jump_width        = out_sjw_r;
  assign out_ch.prop_segment      = out_prop_r;
  assign out_ch.phase_segment_one = out_phase_r;
  assign out_ch.phase_segment_two = out_phase_r;

  `CBTS_ASSERT_IMP(a_scan_product, state_r == S_Q_SCAN,
                   prod_r == PROD_W'(bit_r) * PROD_W'(q_r), "scan product out of step")
  `CBTS_ASSERT_IMP(a_search_p_range,
                   state_r == S_DIV_START || state_r == S_DIV_WAIT || state_r == S_Q_SCAN,
                   p_r >= P_W'(1) && p_r <= P_W'(MAX_PRESCALER), "prescaler out of range")
  `CBTS_ASSERT_IMP(a_ok_fields, out_valid_r && out_status_r == ST_OK,
                   out_presc_r != '0 && out_quanta_r >= QUANTA_W'(MIN_QUANTA)
                   && out_quanta_r <= QUANTA_W'(MAX_QUANTA) && out_sjw_r,
                   "ok result with bad timing fields")
  `CBTS_ASSERT_IMP(a_fail_fields, out_valid_r && out_status_r != ST_OK,
                   out_presc_r == '0 && out_quanta_r == '0 && !out_sjw_r
                   && out_prop_r == '0 && out_phase_r == '0,
                   "failed result with nonzero fields")

endmodule

`default_nettype wire

FILE: verif/cbts_timing_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the configuration port, predicts the bit timing
// for every accepted rate code and compares it with the returned result.
module cbts_timing_checker import cbts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CLK_W-1:0] cfg_wdata,
  cbts_in_if                    in_mon,
  cbts_out_if                   out_mon,
  output int unsigned           results_owed,
  output int unsigned           failures
);

  typedef struct packed {
    status_t             status;
    logic [PRESC_W-1:0]  prescaler;
    logic [QUANTA_W-1:0] quanta_per_bit;
    logic                jump_width;
    logic [SEG_W-1:0]    prop_segment;
    logic [SEG_W-1:0]    phase_segment_one;
    logic [SEG_W-1:0]    phase_segment_two;
  } timing_t;

  typedef struct packed {
    logic [RATE_CODE_W-1:0] rate_code;
    timing_t                timing;
  } owed_timing_t;

  localparam int unsigned MAX_REPORTS = 10;

  logic [CLK_W-1:0] clock_hz;
  owed_timing_t     owed_q [$];
  owed_timing_t     want;
  timing_t          got;
  int unsigned      fail_total = 0;

  assign failures = fail_total;

  // Lowest prescaler first, then the highest quanta count that hits exactly.
  function automatic timing_t solve_timing(input logic [RATE_CODE_W-1:0] code,
                                           input logic [CLK_W-1:0] clk_hz);
    timing_t     r;
    int unsigned bit_rate;
    int unsigned quot;
    int unsigned tq;
    int unsigned phase;
    int unsigned p;
    int unsigned q;
    bit          done;
    r = '0;
    r.status = ST_TOO_LOW;
    done = 1'b0;
    if (code >= NUM_RATES) begin
      r.status = ST_BAD_CODE;
    end else begin
      bit_rate = RATE_BPS[code[RATE_IDX_W-1:0]];
      for (p = 1; p <= MAX_PRESCALER && !done; p++) begin
        quot = clk_hz / p;
        if ((clk_hz % p) == 0 && quot[0] == 1'b0) begin
          tq = quot / 2;
          if (p == 1 && bit_rate > tq / MIN_QUANTA) begin
            r.status = ST_TOO_HIGH;
            done = 1'b1;
          end else if (bit_rate >= tq / MAX_QUANTA && bit_rate <= tq / MIN_QUANTA) begin
            for (q = MAX_QUANTA; q >= MIN_QUANTA && !done; q--) begin
              if ((tq % q) == 0 && (tq / q) == bit_rate) begin
                phase = (q - 1) / 3;
                r.status = ST_OK;
                r.prescaler = PRESC_W'(p);
                r.quanta_per_bit = QUANTA_W'(q);
                r.jump_width = 1'b1;
                r.phase_segment_one = SEG_W'(phase);
                r.phase_segment_two = SEG_W'(phase);
                r.prop_segment = SEG_W'(q - 1 - 2 * phase);
                done = 1'b1;
              end
            end
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_hz <= CLK_HZ_RESET;
      owed_q.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we) begin
        clock_hz <= cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_q.push_back({in_mon.rate_code, solve_timing(in_mon.rate_code, clock_hz)});
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {status_t'(out_mon.status), out_mon.prescaler, out_mon.quanta_per_bit,
               out_mon.jump_width, out_mon.prop_segment, out_mon.phase_segment_one,
               out_mon.phase_segment_two};
        if (owed_q.size() == 0) begin
          fail_total++;
          if (fail_total <= MAX_REPORTS) begin
            $display("%0t: result with no rate code pending: status %0d", $realtime,
                     got.status);
          end
        end else begin
          want = owed_q.pop_front();
          if (got !== want.timing) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS) begin
              $display("%0t: code %0d clock %0d: expected st %0d p %0d q %0d sjw %0d",
                       $realtime, want.rate_code, clock_hz, want.timing.status,
                       want.timing.prescaler, want.timing.quanta_per_bit,
                       want.timing.jump_width);
              $display("  prop %0d ph1 %0d ph2 %0d; got st %0d p %0d q %0d sjw %0d",
                       want.timing.prop_segment, want.timing.phase_segment_one,
                       want.timing.phase_segment_two, got.status, got.prescaler,
                       got.quanta_per_bit, got.jump_width);
              $display("  prop %0d ph1 %0d ph2 %0d", got.prop_segment,
                       got.phase_segment_one, got.phase_segment_two);
            end
          end
        end
      end
      results_owed <= owed_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the bit timing solver. The checker beside the
// block does all prediction and comparison; this module only feeds rate codes,
// applies backpressure, rewrites the clock register between phases and reports
// the outcome.
module testbench;
  import cbts_pkg::*;

  // Rate codes by name. Anything from NUM_RATES up is an invalid code.
  localparam logic [RATE_CODE_W-1:0] CODE_10K  = 4'd0;
  localparam logic [RATE_CODE_W-1:0] CODE_50K  = 4'd2;
  localparam logic [RATE_CODE_W-1:0] CODE_125K = 4'd3;
  localparam logic [RATE_CODE_W-1:0] CODE_500K = 4'd5;
  localparam logic [RATE_CODE_W-1:0] CODE_800K = 4'd6;
  localparam logic [RATE_CODE_W-1:0] CODE_1M   = 4'd7;
  localparam int unsigned LAST_CODE = (1 << RATE_CODE_W) - 1;

  localparam int unsigned CLK_HZ_MAX    = (1 << CLK_W) - 1;
  localparam int unsigned RANDOM_ITEMS  = 110;
  localparam int unsigned MAX_IDLE      = 13;
  localparam int unsigned SETTLE_CYCLES = 40;

  // Clock frequencies that boards commonly run the peripheral from.
  localparam int unsigned NUM_BOARD_CLOCKS = 12;
  localparam int unsigned BOARD_CLOCKS [NUM_BOARD_CLOCKS] = '{
    8000000, 10000000, 16000000, 20000000, 24000000, 32000000,
    40000000, 48000000, 64000000, 80000000, 120000000, 160000000
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CLK_W-1:0] cfg_wdata;
  int unsigned      results_owed;
  int unsigned      failures;
  bit               send_steady;
  bit               take_steady;

  cbts_in_if  in_ch ();
  cbts_out_if out_ch ();

  can_bit_timing_solver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cbts_timing_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .results_owed (results_owed),
    .failures     (failures)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = ~clk;
    end
  end

  // In the slowest correct run every search walks all 64 prescalers, plus the
  // longest idle on both sides; this limit lies well beyond that run.
  initial begin
    #30000000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one rate code and returns at the clock edge that accepts it. Valid
  // is left high so that a following transaction with no gap goes out
  // back to back; this task only lowers it when an idle gap is actually drawn.
  task automatic send_rate_code(input logic [RATE_CODE_W-1:0] code);
    int unsigned gap;
    if ($urandom_range(0, 7) == 0) begin
      send_steady = !send_steady;
    end
    gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rate_code <= code;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops sending and waits until the checker holds no pending result. Each
  // rate code yields exactly one result, so the block is idle afterwards.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // The register may only change while nothing is in flight.
  task automatic set_clock_hz(input logic [CLK_W-1:0] hz);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Picks a clock for one random phase. Most are board clocks or clocks built
  // to give an exact hit somewhere in the search; the rest are arbitrary
  // values, including small ones that push most rates out of reach.
  function automatic logic [CLK_W-1:0] pick_clock_hz();
    longint unsigned hz;
    int unsigned     quanta;
    int unsigned     presc;
    case ($urandom_range(0, 5))
      0, 1, 2: hz = BOARD_CLOCKS[$urandom_range(0, NUM_BOARD_CLOCKS - 1)];
      3: begin
        quanta = $urandom_range(MIN_QUANTA, MAX_QUANTA);
        presc = $urandom_range(1, MAX_PRESCALER);
        hz = longint'(RATE_BPS[$urandom_range(0, NUM_RATES - 1)]) * quanta * 2 * presc;
        if (hz > CLK_HZ_MAX) begin
          hz = longint'(RATE_BPS[CODE_10K]) * quanta * 2 * presc;
        end
      end
      4: hz = $urandom_range(1, CLK_HZ_MAX);
      default: hz = $urandom_range(0, 2000000);
    endcase
    return CLK_W'(hz);
  endfunction

  // Result side: each result is held off for a random number of cycles, with
  // runs where ready simply stays high.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    take_steady = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        take_steady = !take_steady;
      end
      stall = take_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int unsigned code;
    int unsigned sent;
    int unsigned phase_len;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rate_code = '0;
    send_steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every code, valid and invalid, against the 60 MHz reset clock.
    for (code = 0; code <= LAST_CODE; code++) begin
      send_rate_code(RATE_CODE_W'(code));
    end

    // A zero clock is too slow for any rate already at prescaler 1.
    set_clock_hz('0);
    send_rate_code(CODE_1M);
    send_rate_code(CODE_10K);

    // An odd clock skips prescaler 1 and no other prescaler divides 1 Hz.
    set_clock_hz(CLK_W'(1));
    send_rate_code(CODE_10K);

    // The largest clock is odd as well, so the too-high check never runs.
    set_clock_hz(CLK_W'(CLK_HZ_MAX));
    send_rate_code(CODE_10K);
    send_rate_code(CODE_1M);

    // 16 MHz reaches 1 Mbit/s only with the fewest quanta at prescaler 1.
    set_clock_hz(CLK_W'(16000000));
    send_rate_code(CODE_1M);
    send_rate_code(CODE_800K);

    set_clock_hz(CLK_W'(20000000));
    send_rate_code(CODE_500K);
    send_rate_code(CODE_125K);
    send_rate_code(CODE_50K);

    // Random phases, each under its own clock. Most codes are valid so the
    // search does real work; a few invalid ones are mixed in.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_clock_hz(pick_clock_hz());
      phase_len = $urandom_range(8, 20);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 85) begin
          send_rate_code(RATE_CODE_W'($urandom_range(CODE_10K, CODE_1M)));
        end else begin
          send_rate_code(RATE_CODE_W'($urandom_range(NUM_RATES, LAST_CODE)));
        end
        sent++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cbts_pkg.sv
hdl/cbts_if.sv
hdl/cbts_divider.sv
hdl/can_bit_timing_solver.sv
verif/cbts_timing_checker.sv
verif/testbench.sv
